### src/bld_pkg.sv
package bld_pkg;

   localparam int ADC_BITS   = 12;
   localparam int TOL_BITS   = 12;
   localparam int NUM_LEVELS = 15;
   localparam int SLOT_BITS  = $clog2(NUM_LEVELS + 1);
   localparam int CMP_BITS   = ((ADC_BITS > TOL_BITS) ? ADC_BITS : TOL_BITS) + 2;
   localparam int MASK_BITS  = 8;
   localparam int LINE_BITS  = 8;
   localparam int CSR_IDX_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_HW_MODE   = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE = CSR_IDX_BITS'(1);

   localparam logic ACT_CLASSIFY = 1'b0;
   localparam logic ACT_CALIB    = 1'b1;

   localparam logic MODE_ANALOG  = 1'b0;
   localparam logic MODE_DIGITAL = 1'b1;

   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(50);

   localparam logic [MASK_BITS-1:0] M_FRONT = 8'h01;
   localparam logic [MASK_BITS-1:0] M_RIGHT = 8'h04;
   localparam logic [MASK_BITS-1:0] M_REAR  = 8'h10;
   localparam logic [MASK_BITS-1:0] M_LEFT  = 8'h40;

   typedef logic [NUM_LEVELS-1:0][ADC_BITS-1:0] cal_table_type;

   // capture request from the pipeline into the calibration store
   typedef struct packed {
      logic                step;
      logic [ADC_BITS-1:0] level;
   } cal_cmd_type;

   // pressed mask for each calibration slot, combination order of the ladder
   function automatic logic [MASK_BITS-1:0] level_mask(input logic [SLOT_BITS-1:0] idx);
      logic [MASK_BITS-1:0] m;
      case (idx)
         4'd0:    m = M_LEFT;
         4'd1:    m = M_RIGHT;
         4'd2:    m = M_RIGHT | M_LEFT;
         4'd3:    m = M_REAR;
         4'd4:    m = M_REAR | M_LEFT;
         4'd5:    m = M_REAR | M_RIGHT;
         4'd6:    m = M_REAR | M_LEFT | M_RIGHT;
         4'd7:    m = M_FRONT;
         4'd8:    m = M_FRONT | M_LEFT;
         4'd9:    m = M_FRONT | M_RIGHT;
         4'd10:   m = M_FRONT | M_RIGHT | M_LEFT;
         4'd11:   m = M_FRONT | M_REAR;
         4'd12:   m = M_FRONT | M_REAR | M_LEFT;
         4'd13:   m = M_FRONT | M_REAR | M_RIGHT;
         4'd14:   m = M_FRONT | M_REAR | M_RIGHT | M_LEFT;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### src/bld_calib.sv
module bld_calib (
   input  logic                  clock,
   input  logic                  reset,
   input  bld_pkg::cal_cmd_type  cmd,
   output bld_pkg::cal_table_type table_q,
   output logic                  seq_done
);
   import bld_pkg::*;

   cal_table_type          table_ff, table_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;

   assign seq_done = (slot_ff == SLOT_BITS'(NUM_LEVELS));
   assign table_q  = table_ff;

   always_comb begin
      table_in = table_ff;
      slot_in  = slot_ff;
      if (cmd.step) begin
         if (seq_done) begin
            slot_in = '0;
         end else begin
            table_in[slot_ff] = cmd.level;
            slot_in           = slot_ff + SLOT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff <= '0;
         slot_ff  <= '0;
      end else begin
         table_ff <= table_in;
         slot_ff  <= slot_in;
      end
   end

   a_rewind: assert property (@(posedge clock) disable iff (reset)
      cmd.step && seq_done |=> slot_ff == '0)
      else $error("slot did not rewind after full sequence");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.step && !seq_done |=> slot_ff == $past(slot_ff) + SLOT_BITS'(1)
         && table_ff[$past(slot_ff)] == $past(cmd.level))
      else $error("capture did not store level and advance");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.step |=> $stable(slot_ff) && $stable(table_ff))
      else $error("calibration state changed without a step");

endmodule

### src/bld_classify.sv
module bld_classify (
   input  bld_pkg::cal_table_type          table_q,
   input  logic [bld_pkg::ADC_BITS-1:0]    level,
   input  logic [bld_pkg::TOL_BITS-1:0]    tolerance,
   output logic [bld_pkg::MASK_BITS-1:0]   mask
);
   import bld_pkg::*;

   logic [NUM_LEVELS-1:0]        hit;
   logic signed [CMP_BITS-1:0]   lv;
   logic signed [CMP_BITS-1:0]   tol;

   assign lv  = signed'(CMP_BITS'(level));
   assign tol = signed'(CMP_BITS'(tolerance));

   // all windows compared in parallel, widened so the bounds never wrap
   always_comb begin
      logic signed [CMP_BITS-1:0] cal;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         cal    = signed'(CMP_BITS'(table_q[i]));
         hit[i] = (lv > cal - tol) && (lv < cal + tol);
      end
   end

   // lowest matching slot wins
   always_comb begin
      mask = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            mask = level_mask(SLOT_BITS'(i));
         end
      end
   end

endmodule

### src/bumper_ladder_window_decoder.sv
// Bumper contact decoder. Each request transfer carries one ADC level of the
// resistor ladder and a snapshot of eight active-low switch lines; tuser picks
// classify (0) or calibration capture (1). Classify in analog mode matches the
// level against fifteen stored calibration windows (half width window_tolerance)
// and returns the pressed mask of the first hit, 0 if none; in digital mode it
// returns the inverted switch lines. Capture stores the level into the next
// slot; the sixteenth capture returns calib_done and rewinds. Every request
// yields exactly one response. One item is taken per clock while responses are
// accepted; the path is an input register, the fifteen parallel window compares
// and a response register. A response that is held back stalls the input
// stage, which then holds one more item. The calibration table resets to
// zero. Write csr registers only while idle.
module bumper_ladder_window_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] raw_level, [19:12] switch_lines, [23:20] zero
   input  logic        req_tuser,   // [0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pressed_mask
   output logic        rsp_tuser,   // [0] calib_done
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bld_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bld_pkg::TOL_BITS-1:0]      csr_data
);
   import bld_pkg::*;

   logic                   hw_mode_ff;
   logic [TOL_BITS-1:0]    tol_ff;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_action_ff;
   logic [ADC_BITS-1:0]    s1_level_ff;
   logic [LINE_BITS-1:0]   s1_lines_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [MASK_BITS-1:0]   out_mask_ff, out_mask_in;
   logic                   out_done_ff, out_done_in;

   logic                   advance;
   logic                   move;
   logic                   req_xfer;
   cal_cmd_type            cmd;
   cal_table_type          table_q;
   logic                   seq_done;
   logic [MASK_BITS-1:0]   analog_mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_mode_ff <= MODE_ANALOG;
         tol_ff     <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HW_MODE:   hw_mode_ff <= csr_data[0];
            CSR_TOLERANCE: tol_ff     <= csr_data;
            default:       ;
         endcase
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign move       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in = req_xfer || (s1_valid_ff && !advance);

   assign cmd.step  = move && (s1_action_ff == ACT_CALIB);
   assign cmd.level = s1_level_ff;

   bld_calib u_calib (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .table_q  (table_q),
      .seq_done (seq_done)
   );

   bld_classify u_classify (
      .table_q   (table_q),
      .level     (s1_level_ff),
      .tolerance (tol_ff),
      .mask      (analog_mask)
   );

   always_comb begin
      out_mask_in = '0;
      out_done_in = 1'b0;
      if (s1_action_ff == ACT_CALIB) begin
         out_done_in = seq_done;
      end else if (hw_mode_ff == MODE_DIGITAL) begin
         out_mask_in = ~s1_lines_ff;
      end else begin
         out_mask_in = analog_mask;
      end
   end

   assign out_valid_in = move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_action_ff <= req_tuser;
         s1_level_ff  <= req_tdata[ADC_BITS-1:0];
         s1_lines_ff  <= req_tdata[ADC_BITS +: LINE_BITS];
      end
      if (move) begin
         out_mask_ff <= out_mask_in;
         out_done_ff <= out_done_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_mask_ff;
   assign rsp_tuser  = out_done_ff;

   a_done_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("calibration response carries a pressed mask");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_level_ff)
         && $stable(s1_action_ff))
      else $error("input stage lost an item while stalled");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty input stage refused a transfer");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("item advanced without filling the response register");

endmodule

### sim/bumper_ladder_window_decoder_tb.sv
module bumper_ladder_window_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bld_pkg::*;

   localparam int TOTAL_ITEMS  = 1120;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 4;

   // mask per calibration slot, slot 0 in the lowest byte
   localparam logic [NUM_LEVELS-1:0][MASK_BITS-1:0] COMBO_MASK = {
      M_FRONT | M_REAR | M_RIGHT | M_LEFT,
      M_FRONT | M_REAR | M_RIGHT,
      M_FRONT | M_REAR | M_LEFT,
      M_FRONT | M_REAR,
      M_FRONT | M_RIGHT | M_LEFT,
      M_FRONT | M_RIGHT,
      M_FRONT | M_LEFT,
      M_FRONT,
      M_REAR | M_LEFT | M_RIGHT,
      M_REAR | M_RIGHT,
      M_REAR | M_LEFT,
      M_REAR,
      M_RIGHT | M_LEFT,
      M_RIGHT,
      M_LEFT
   };

   typedef struct packed {
      logic                 action;
      logic [ADC_BITS-1:0]  level;
      logic [LINE_BITS-1:0] lines;
   } bump_req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0] mask;
      logic                 done;
   } bump_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [TOL_BITS-1:0]     csr_data = '0;

   // decoder state as the block should hold it
   logic [ADC_BITS-1:0]  cal_levels [NUM_LEVELS];
   logic [SLOT_BITS-1:0] cal_slot;
   logic                 mode_q;
   logic [TOL_BITS-1:0]  tol_q;

   bump_req_type req_q [$];
   bump_rsp_type decoded_q [$];
   bump_req_type req_cur;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int stall_asked = 0;
   int queued_items = 0;
   int req_sent = 0;
   int rsp_seen = 0;
   int done_seen = 0;
   int csr_writes = 0;
   int mismatch_count = 0;

   bumper_ladder_window_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bump_rsp_type decode_bumpers(input bump_req_type r);
      bump_rsp_type o;
      int lv;
      int cal;
      int tol;
      int i;
      bit hit;
      o = '0;
      hit = 1'b0;
      if (r.action == ACT_CALIB) begin
         if (cal_slot < NUM_LEVELS) begin
            cal_levels[cal_slot] = r.level;
            cal_slot = cal_slot + 1'b1;
         end else begin
            // sequence complete, rewind
            o.done = 1'b1;
            cal_slot = '0;
         end
      end else if (mode_q == MODE_DIGITAL) begin
         o.mask = ~r.lines;
      end else begin
         lv = int'(r.level);
         tol = int'(tol_q);
         for (i = 0; i < NUM_LEVELS; i++) begin
            cal = int'(cal_levels[i]);
            if (!hit && lv > cal - tol && lv < cal + tol) begin
               o.mask = COMBO_MASK[i];
               hit = 1'b1;
            end
         end
      end
      return o;
   endfunction

   initial begin
      for (int i = 0; i < NUM_LEVELS; i++) cal_levels[i] = '0;
      cal_slot = '0;
      mode_q = MODE_ANALOG;
      tol_q = TOL_RESET;
   end

   always @(posedge clock) begin : req_driver
      int req_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decoded_q.push_back(decode_bumpers(req_cur));
            req_sent++;
            req_gap = req_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered item
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (req_q.size() > 0) begin
            req_cur = req_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {4'h0, req_cur.lines, req_cur.level};
            req_tuser <= req_cur.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bump_rsp_type want;
      int rsp_wait;
      int hold_left;
      int stall_taken;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
         stall_taken = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (decoded_q.size() == 0) begin
               $error("response with nothing expected: pressed_mask %02h calib_done %b",
                      rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata !== want.mask) begin
                  $error("pressed_mask expected %02h got %02h", want.mask, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.done) begin
                  $error("calib_done expected %b got %b", want.done, rsp_tuser);
                  mismatch_count++;
               end
               if (want.done) done_seen++;
            end
            rsp_wait = rsp_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (stall_taken != stall_asked) begin
            stall_taken = stall_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic act, input logic [ADC_BITS-1:0] lvl,
                            input logic [LINE_BITS-1:0] lines);
      bump_req_type r;
      r.action = act;
      r.level = lvl;
      r.lines = lines;
      req_q.push_back(r);
      queued_items++;
   endtask

   // block is idle once every transfer has its response
   task automatic wait_drained();
      @(negedge clock);
      while (req_q.size() != 0 || req_tvalid || decoded_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [TOL_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_HW_MODE) mode_q = val[0];
      else if (idx == CSR_TOLERANCE) tol_q = val;
      csr_writes++;
      @(negedge clock);
   endtask

   // classify level close to a stored window, edges included
   function automatic logic [ADC_BITS-1:0] near_level();
      int base;
      int span;
      int v;
      base = int'(cal_levels[$urandom_range(0, NUM_LEVELS - 1)]);
      span = ((tol_q > 300) ? 300 : int'(tol_q)) + 2;
      case ($urandom_range(0, 3))
         0: v = base + ($urandom_range(0, 1) ? int'(tol_q) : -int'(tol_q));
         1: v = base + ($urandom_range(0, 1) ? int'(tol_q) - 1 : 1 - int'(tol_q));
         default: v = base + int'($urandom_range(0, 2 * span)) - span;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[ADC_BITS-1:0];
   endfunction

   task automatic push_calib_run();
      int k;
      int step;
      int start;
      bit down;
      bit scatter;
      int lvl;
      step = $urandom_range(150, 285);
      start = $urandom_range(0, 4095 - 14 * step - 40);
      down = ($urandom_range(0, 1) == 1);
      scatter = ($urandom_range(0, 3) == 0);
      for (k = 0; k < NUM_LEVELS; k++) begin
         lvl = down ? start + (14 - k) * step : start + k * step;
         lvl = scatter ? $urandom_range(0, 4095) : lvl + $urandom_range(0, 40);
         push_item(ACT_CALIB, lvl[ADC_BITS-1:0], LINE_BITS'($urandom));
      end
      push_item(ACT_CALIB, ADC_BITS'($urandom), LINE_BITS'($urandom));
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int k;
      int pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // zeroed table after reset: every window sits around zero and slot 0 wins
      push_item(ACT_CLASSIFY, 12'd0, 8'hFF);
      push_item(ACT_CLASSIFY, 12'd49, 8'h00);
      push_item(ACT_CLASSIFY, 12'd50, 8'h5A);
      push_item(ACT_CLASSIFY, 12'd4095, 8'h00);
      for (k = 0; k < NUM_LEVELS - 1; k++) push_item(ACT_CALIB, 12'(k * 280 + 40), 8'h00);
      push_item(ACT_CALIB, 12'd4095, 8'hFF);
      push_item(ACT_CALIB, 12'd1234, 8'h00);
      push_item(ACT_CLASSIFY, 12'd4095, 8'h00);
      push_item(ACT_CLASSIFY, 12'd4045, 8'h00);
      push_item(ACT_CLASSIFY, 12'd4046, 8'h00);
      wait_drained();

      // empty windows with zero tolerance
      write_csr(CSR_TOLERANCE, 12'd0);
      push_item(ACT_CLASSIFY, 12'd40, 8'h00);
      wait_drained();
      // widest windows: slot 0 always wins
      write_csr(CSR_TOLERANCE, 12'hFFF);
      push_item(ACT_CLASSIFY, 12'd2000, 8'h00);
      wait_drained();
      write_csr(CSR_HW_MODE, {11'h0, MODE_DIGITAL});
      write_csr(8'hFF, 12'hABC);
      push_item(ACT_CLASSIFY, 12'd0, 8'h00);
      push_item(ACT_CLASSIFY, 12'hFFF, 8'hFF);
      push_item(ACT_CLASSIFY, 12'd7, 8'hA5);
      push_item(ACT_CALIB, 12'd777, 8'h3C);

      phase = 0;
      while (queued_items < TOTAL_ITEMS) begin
         phase++;
         wait_drained();
         if ($urandom_range(0, 4) != 0) begin
            write_csr(CSR_HW_MODE, $urandom_range(0, 3) == 0 ?
                      {11'($urandom_range(0, 2047)), MODE_DIGITAL} :
                      {11'($urandom_range(0, 2047)), MODE_ANALOG});
            case ($urandom_range(0, 5))
               0: write_csr(CSR_TOLERANCE, 12'd0);
               1: write_csr(CSR_TOLERANCE, 12'hFFF);
               2: write_csr(CSR_TOLERANCE, TOL_RESET);
               default: write_csr(CSR_TOLERANCE, TOL_BITS'($urandom_range(1, 300)));
            endcase
         end
         if ($urandom_range(0, 5) == 0) begin
            write_csr(CSR_IDX_BITS'($urandom_range(2, 255)), TOL_BITS'($urandom));
         end
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (phase == 2 || phase == 9) begin
            // sender keeps offering while the response side stalls
            req_idle_on = 1'b0;
            stall_asked++;
         end
         n = $urandom_range(40, 90);
         while (n > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               push_calib_run();
               n -= 16;
            end else if (pick < 17) begin
               push_item(ACT_CALIB, ADC_BITS'($urandom), LINE_BITS'($urandom));
               n--;
            end else if (pick < 35) begin
               push_item(ACT_CLASSIFY, ADC_BITS'($urandom), LINE_BITS'($urandom));
               n--;
            end else begin
               push_item(ACT_CLASSIFY, near_level(), LINE_BITS'($urandom));
               n--;
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (decoded_q.size() != 0) begin
         $error("%0d responses never arrived", decoded_q.size());
         mismatch_count++;
      end
      $display("decoded %0d requests into %0d responses, %0d calibration runs completed",
               req_sent, rsp_seen, done_seen);
      $display("%0d csr writes across analog and digital modes, zero to full tolerance",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

### bumper_ladder_window_decoder.f
src/bld_pkg.sv
src/bld_calib.sv
src/bld_classify.sv
src/bumper_ladder_window_decoder.sv
sim/bumper_ladder_window_decoder_tb.sv
